FILE: src/line_editor_with_echo_assert.svh
// assertion macros shared by the line editor modules
`ifndef LINE_EDITOR_WITH_ECHO_ASSERT_SVH
`define LINE_EDITOR_WITH_ECHO_ASSERT_SVH
`ifndef SYNTHESIS
`define LEWE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LEWE_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define LEWE_ASSERT(lbl, clk, rst_n, prop, msg)
`define LEWE_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: src/lewe_pkg.sv
// types, codes and constants of the line editor
package lewe_pkg;

  localparam int LINE_SIZE_DEF = 64;
  localparam int CAP_W         = 7;
  localparam int LEN_W         = 6;
  localparam int IDX_W         = 6;
  localparam int STATUS_W      = 2;
  localparam int CMD_W         = 2;
  localparam int STEP_W        = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_CHAR    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd3;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_TILD = 8'h7E;
  localparam logic [7:0] CH_DEL  = 8'h7F;

  typedef enum logic [1:0] {
    MODE_RESTART  = 2'd0,
    MODE_INPUT    = 2'd1,
    MODE_COMPLETE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ECHO_NONE  = 2'd0,
    ECHO_CRLF  = 2'd1,
    ECHO_ERASE = 2'd2,
    ECHO_CHAR  = 2'd3
  } echo_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [7:0]       char_in;
    logic [IDX_W-1:0] read_index;
  } in_t;

  typedef struct packed {
    logic                echo_valid;
    logic [7:0]          echo_byte;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    line_length;
    logic [7:0]          read_byte;
    logic                last;
  } out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic                prompt;
    echo_e               kind;
    logic [7:0]          ch;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    length;
    logic                rd_ok;
  } desc_t;

  typedef struct packed {
    desc_t      desc;
    logic [7:0] rbyte;
  } entry_t;

endpackage

FILE: src/line_editor_with_echo.sv
// Terminal line editor with echo. Requests enter through a queue-like port
// (push/full) and results leave through another (empty/pop). A character
// request yields the echo for it, preceded by the "# " prompt when a restart
// is pending; a restart yields the prompt; a read returns one stored byte.
// Every request gives one to five results, the final one marked by last.
// The front end takes one request per clock while its four-entry queue has
// room, so a new request is accepted while earlier results still wait. The
// back end hands out one result per clock while pop is high and the queue
// is not empty, so a request holds the output for as many pops as it has
// results; its first result goes through the stage register and the queue.
// The line store is a single write port ram with registered read and needs
// no clearing after reset. Write the capacity register only while the block is idle.
module line_editor_with_echo import lewe_pkg::*; #(
  parameter int LineSize = LINE_SIZE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  input  logic             push,
  output logic             full,
  input  in_t              item_i,
  output logic             empty,
  input  logic             pop,
  output out_t             result_o
);

  localparam int AW = (LineSize > 1) ? $clog2(LineSize) : 1;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;
  logic              q_push, q_pop, q_valid;
  entry_t            q_entry, q_head;
  logic [QCNT_W-1:0] q_cnt;

  lewe_front #(
    .LineSize(LineSize)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .full       (full),
    .item_i     (item_i),
    .q_cnt_i    (q_cnt),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry)
  );

  lewe_ram #(
    .Width(8),
    .Depth(LineSize)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  lewe_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_entry),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .head_o (q_head),
    .cnt_o  (q_cnt)
  );

  lewe_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_head_i (q_head),
    .q_pop_o  (q_pop),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

endmodule

FILE: src/lewe_ram.sv
// generic single write port ram with registered read
module lewe_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/lewe_front.sv
// front end: takes requests, updates mode and length, classifies the echo
module lewe_front import lewe_pkg::*; #(
  parameter int LineSize = LINE_SIZE_DEF,
  localparam int AW = (LineSize > 1) ? $clog2(LineSize) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CAP_W-1:0]  cfg_wdata_i,
  input  logic              push,
  output logic              full,
  input  in_t               item_i,
  input  logic [QCNT_W-1:0] q_cnt_i,
  output logic              ram_we_o,
  output logic [AW-1:0]     ram_waddr_o,
  output logic [7:0]        ram_wdata_o,
  output logic [AW-1:0]     ram_raddr_o,
  input  logic [7:0]        ram_rdata_i,
  output logic              q_push_o,
  output entry_t            q_entry_o
);

  localparam int CW = ((AW > CAP_W) ? AW : CAP_W) + 1;
  localparam logic [CW-1:0] SizeC = CW'(LineSize);

  mode_e            mode_q, mode_d;
  logic [AW-1:0]    fill_q, fill_d;
  logic [CAP_W-1:0] cap_q;
  desc_t            s1_q, desc;
  logic             s1_valid_q;

  logic          accept, act, prompt_c, store_full;
  logic          is_eol, is_nul, is_del, is_prn;
  logic [AW-1:0] fill0;
  logic [CW-1:0] cap_ext, eff_cap;
  logic [7:0]    c;

  // an item in the stage register still needs a slot in the queue
  assign full   = ({1'b0, q_cnt_i} + {{QCNT_W{1'b0}}, s1_valid_q})
                  >= (QCNT_W + 1)'(QUEUE_DEPTH);
  assign accept = push && !full;
  assign c      = item_i.char_in;

  assign act      = (item_i.command == CMD_CHAR) && (mode_q != MODE_COMPLETE);
  assign prompt_c = (act && (mode_q != MODE_INPUT)) || (item_i.command == CMD_RESTART);
  assign fill0    = prompt_c ? '0 : fill_q;

  assign is_eol = (c == CH_CR) || (c == CH_LF);
  assign is_nul = (c == CH_NUL);
  assign is_del = (c == CH_BS) || (c == CH_DEL);
  assign is_prn = (c >= CH_SP) && (c <= CH_TILD);

  assign cap_ext    = CW'(cap_q);
  assign eff_cap    = (cap_ext < SizeC) ? cap_ext : SizeC;
  assign store_full = (CW'(fill0) + CW'(1)) >= eff_cap;

  // next state
  always_comb begin
    mode_d = mode_q;
    fill_d = fill_q;
    if (accept) begin
      case (item_i.command)
        CMD_CHAR: begin
          if (act) begin
            mode_d = MODE_INPUT;
            fill_d = fill0;
            if (is_eol || is_nul) begin
              mode_d = MODE_COMPLETE;
            end else if (is_del && (fill0 != '0)) begin
              fill_d = fill0 - AW'(1);
            end else if (is_prn && !store_full) begin
              fill_d = fill0 + AW'(1);
            end
          end
        end
        CMD_RESTART: begin
          mode_d = MODE_INPUT;
          fill_d = '0;
        end
        default: ;
      endcase
    end
  end

  // classification for the back end
  always_comb begin
    desc.prompt = prompt_c;
    desc.ch     = c;
    if (act && is_eol) begin
      desc.kind = ECHO_CRLF;
    end else if (act && is_del && (fill0 != '0)) begin
      desc.kind = ECHO_ERASE;
    end else if (act && is_prn && !store_full) begin
      desc.kind = ECHO_CHAR;
    end else begin
      desc.kind = ECHO_NONE;
    end
    desc.status = (act && is_prn && store_full) ? STATUS_FULL : STATUS_W'(mode_d);
    desc.length = LEN_W'(fill_d);
    desc.rd_ok  = (item_i.command == CMD_READ)
                  && (CW'(item_i.read_index) < CW'(fill_q));
  end

  assign ram_we_o    = accept && act && is_prn && !store_full;
  assign ram_waddr_o = fill0;
  assign ram_wdata_o = c;
  assign ram_raddr_o = AW'(item_i.read_index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_RESTART;
      fill_q     <= '0;
      cap_q      <= CAP_RESET;
      s1_valid_q <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      fill_q     <= fill_d;
      s1_valid_q <= accept;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= desc;
    end
  end

  // ram data arrives in the cycle after the read address, with the stage register
  assign q_push_o        = s1_valid_q;
  assign q_entry_o.desc  = s1_q;
  assign q_entry_o.rbyte = s1_q.rd_ok ? ram_rdata_i : 8'h00;

endmodule

FILE: src/lewe_queue.sv
// short queue of classified requests between front and back
`include "line_editor_with_echo_assert.svh"
module lewe_queue import lewe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  entry_t            entry_i,
  input  logic              pop_i,
  output logic              valid_o,
  output entry_t            head_o,
  output logic [QCNT_W-1:0] cnt_o
);

  entry_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr_q, rptr_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic                do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];
  assign cnt_o   = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
      case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  `LEWE_ASSERT(a_q_no_overflow, clk_i, rst_ni, !(push_i && !do_pop && (cnt_q == QCNT_W'(QUEUE_DEPTH))), "request queue overflow")
  `LEWE_ASSERT(a_q_cnt_range, clk_i, rst_ni, cnt_q <= QCNT_W'(QUEUE_DEPTH), "request queue count out of range")

endmodule

FILE: src/lewe_back.sv
// back end: expands each request into its echo bytes, one result per pop
`include "line_editor_with_echo_assert.svh"
module lewe_back import lewe_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   q_valid_i,
  input  entry_t q_head_i,
  output logic   q_pop_o,
  output logic   empty,
  input  logic   pop,
  output out_t   result_o
);

  logic [STEP_W-1:0] step_q;
  logic [STEP_W-1:0] kind_len, nbytes, total, j;
  logic [7:0]        byte_c;
  logic              is_last, take;
  desc_t             d;

  assign d     = q_head_i.desc;
  assign empty = !q_valid_i;
  assign take  = pop && q_valid_i;

  always_comb begin
    case (d.kind)
      ECHO_CRLF:  kind_len = STEP_W'(2);
      ECHO_ERASE: kind_len = STEP_W'(3);
      ECHO_CHAR:  kind_len = STEP_W'(1);
      default:    kind_len = '0;
    endcase
  end

  assign nbytes  = (d.prompt ? STEP_W'(2) : '0) + kind_len;
  assign total   = (nbytes == '0) ? STEP_W'(1) : nbytes;
  assign is_last = (step_q == total - STEP_W'(1));
  assign j       = d.prompt ? (step_q - STEP_W'(2)) : step_q;

  always_comb begin
    if (d.prompt && (step_q == '0)) begin
      byte_c = CH_HASH;
    end else if (d.prompt && (step_q == STEP_W'(1))) begin
      byte_c = CH_SP;
    end else begin
      case (d.kind)
        ECHO_CRLF:  byte_c = (j == '0) ? CH_CR : CH_LF;
        ECHO_ERASE: byte_c = (j == STEP_W'(1)) ? CH_SP : CH_BS;
        ECHO_CHAR:  byte_c = d.ch;
        default:    byte_c = 8'h00;
      endcase
    end
  end

  assign result_o.echo_valid  = (nbytes != '0);
  assign result_o.echo_byte   = (nbytes != '0) ? byte_c : 8'h00;
  assign result_o.status      = d.status;
  assign result_o.line_length = d.length;
  assign result_o.read_byte   = q_head_i.rbyte;
  assign result_o.last        = is_last;

  assign q_pop_o = take && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (take) begin
      step_q <= is_last ? '0 : (step_q + STEP_W'(1));
    end
  end

  `LEWE_ASSERT(a_step_idle, clk_i, rst_ni, q_valid_i || (step_q == '0), "step count moved with no request")
  `LEWE_ASSERT(a_step_range, clk_i, rst_ni, !q_valid_i || (step_q < total), "step count past request end")
  `LEWE_ASSERT_NEXT(a_step_wrap, clk_i, rst_ni, take && is_last, step_q == '0, "step count not cleared after last byte")

endmodule
